// ----- rtl/mcse_pkg.sv -----
`default_nettype none

package mcse_pkg;

	// Field widths of the stream items.
	localparam int IDX_W      = 20;
	localparam int FLAGS_W    = 10;
	localparam int NN_W       = 13;
	localparam int WGT_W      = 32;
	localparam int VAL_W      = 38;
	localparam int COL_W      = 21;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 64;

	// Internal widths: signed grid positions and the wide partial sums.
	localparam int POS_W  = 23;
	localparam int SUM_W  = 40;
	localparam int COEF_W = 4;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_X     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_Y     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CROSS = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [NN_W-1:0]  ROW_WIDTH_RST = 13'd64;
	localparam logic [WGT_W-1:0] WEIGHT_RST    = 32'd65536;

	// Weight selectors of the stencils.
	localparam int WSEL_X     = 0;
	localparam int WSEL_Y     = 1;
	localparam int WSEL_CROSS = 2;

	// Stencil table: taps as row offset (times the row width) and column
	// offset, with their integer coefficients, in ascending position order.
	localparam int NUM_ST  = 10;
	localparam int MAX_TAP = 4;
	localparam int GRID_R  = 2;
	localparam int GRID_D  = 5;

	localparam int ST_CNT [NUM_ST] = '{3, 3, 3, 4, 4, 4, 4, 3, 3, 3};
	localparam int ST_WSEL [NUM_ST] = '{WSEL_X, WSEL_X, WSEL_X, WSEL_CROSS, WSEL_CROSS,
		WSEL_CROSS, WSEL_CROSS, WSEL_Y, WSEL_Y, WSEL_Y};
	localparam int ST_ROW [NUM_ST][MAX_TAP] = '{
		'{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0},
		'{0, 0, 1, 1}, '{0, 0, 1, 1}, '{-1, -1, 0, 0}, '{-1, -1, 0, 0},
		'{0, 1, 2, 0}, '{-1, 0, 1, 0}, '{-2, -1, 0, 0}};
	localparam int ST_COL [NUM_ST][MAX_TAP] = '{
		'{0, 1, 2, 0}, '{-1, 0, 1, 0}, '{-2, -1, 0, 0},
		'{0, 1, 0, 1}, '{-1, 0, -1, 0}, '{0, 1, 0, 1}, '{-1, 0, -1, 0},
		'{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}};
	localparam int ST_COEF [NUM_ST][MAX_TAP] = '{
		'{1, -2, 1, 0}, '{-2, 4, -2, 0}, '{1, -2, 1, 0},
		'{1, -1, -1, 1}, '{-1, 1, 1, -1}, '{-1, 1, 1, -1}, '{1, -1, -1, 1},
		'{1, -2, 1, 0}, '{-2, 4, -2, 0}, '{1, -2, 1, 0}};

	// Fallback neighbor list, scanned in this order.
	localparam int NUM_FB = 13;
	localparam int FB_ROW [NUM_FB] = '{-2, -1, -1, -1, 0, 0, 0, 0, 0, 1, 1, 1, 2};
	localparam int FB_COL [NUM_FB] = '{0, -1, 0, 1, -2, -1, 0, 1, 2, -1, 0, 1, 0};

	// Number of stencils reduced together in the first sum/min stage.
	localparam int GRP_N = 5;
	localparam int NUM_GRP = NUM_ST / GRP_N;

endpackage

`default_nettype wire

// ----- rtl/masked_curvature_stencil_element.sv -----
`default_nettype none

// Channel  | Signals                     | Contents
// s        | s_tvalid s_tready s_tdata   | request: row, column, fixed flags, stencil flags
// m        | m_tvalid m_tready m_tdata   | result: element value, next column, no-next flag
// cfg      | cfg_we cfg_index cfg_data   | row width and the three weights, write only
//
// Six register stages; one request enters per cycle while the stall enable is
// high. Throughput is set by the single shared stall enable, which advances
// every stage when the output register is empty or being taken. Reset clears
// all valid bits and loads the configuration registers with their defaults.
// A stall holds every stage; nothing is dropped or repeated.
module masked_curvature_stencil_element
	import mcse_pkg::*;
#(
	parameter int MAX_ROW_WIDTH = 4096
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        s_tvalid,
	output logic                       s_tready,
	// row_index[19:0], column_index[39:20], row_fixed[40], column_fixed[41],
	// stencil_flags[51:42], zero[55:52]
	input  wire  [IN_DATA_W-1:0]       s_tdata,
	output logic                       m_tvalid,
	input  wire                        m_tready,
	// element_value[37:0], next_column[58:38], next_none[59], zero[63:60]
	output logic [OUT_DATA_W-1:0]      m_tdata,
	input  wire                        cfg_we,
	input  wire  [CFG_IDX_W-1:0]       cfg_index,
	input  wire  [WGT_W-1:0]           cfg_data
);

	// Configuration registers.
	logic [NN_W-1:0]  row_width_q;
	logic [WGT_W-1:0] weight_x_q;
	logic [WGT_W-1:0] weight_y_q;
	logic [WGT_W-1:0] weight_cross_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q    <= ROW_WIDTH_RST;
			weight_x_q     <= WEIGHT_RST;
			weight_y_q     <= WEIGHT_RST;
			weight_cross_q <= WEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_WIDTH:    row_width_q    <= cfg_data[NN_W-1:0];
				REG_WEIGHT_X:     weight_x_q     <= cfg_data;
				REG_WEIGHT_Y:     weight_y_q     <= cfg_data;
				REG_WEIGHT_CROSS: weight_cross_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective row width: zero acts as one, and it is capped at the maximum.
	logic [NN_W-1:0] nn_eff;

	always_comb begin
		if (row_width_q == '0) begin
			nn_eff = NN_W'(1);
		end else if (32'(row_width_q) > 32'(MAX_ROW_WIDTH)) begin
			nn_eff = NN_W'(MAX_ROW_WIDTH);
		end else begin
			nn_eff = row_width_q;
		end
	end

	// Pipeline valid bits and the shared stall enable.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en;

	assign en       = !v_s6 || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 1: capture the request and decide whether the fallback list applies.
	logic [IDX_W-1:0]   i_s1;
	logic [IDX_W-1:0]   j_s1;
	logic [FLAGS_W-1:0] flags_s1;
	logic               fb_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			i_s1     <= s_tdata[IDX_W-1:0];
			j_s1     <= s_tdata[2*IDX_W-1:IDX_W];
			flags_s1 <= s_tdata[2*IDX_W+2+FLAGS_W-1:2*IDX_W+2];
			fb_s1    <= s_tdata[2*IDX_W] || s_tdata[2*IDX_W+1] ||
				(s_tdata[2*IDX_W+2+FLAGS_W-1:2*IDX_W+2] == '0);
		end
	end

	// Stage 2: row bases i + r * NN for the five grid rows.
	logic signed [POS_W-1:0] base_s2 [GRID_D];
	logic [IDX_W-1:0]        j_s2;
	logic [FLAGS_W-1:0]      flags_s2;
	logic                    fb_s2;
	logic signed [POS_W-1:0] i_ext;
	logic signed [POS_W-1:0] nn_ext;

	assign i_ext  = signed'({{(POS_W-IDX_W){1'b0}}, i_s1});
	assign nn_ext = signed'({{(POS_W-NN_W){1'b0}}, nn_eff});

	always_ff @(posedge clk) begin
		if (en) begin
			base_s2[0] <= i_ext - (nn_ext <<< 1);
			base_s2[1] <= i_ext - nn_ext;
			base_s2[2] <= i_ext;
			base_s2[3] <= i_ext + nn_ext;
			base_s2[4] <= i_ext + (nn_ext <<< 1);
			j_s2       <= j_s1;
			flags_s2   <= flags_s1;
			fb_s2      <= fb_s1;
		end
	end

	// Stage 3: every grid position, compared against the column.
	logic signed [POS_W-1:0] pos_c [GRID_D][GRID_D];
	logic signed [POS_W-1:0] j_ext;
	logic [COL_W-1:0]        pos_s3 [GRID_D][GRID_D];
	logic [GRID_D-1:0]       lt_s3 [GRID_D];
	logic [GRID_D-1:0]       eq_s3 [GRID_D];
	logic [FLAGS_W-1:0]      flags_s3;
	logic                    fb_s3;

	assign j_ext = signed'({{(POS_W-IDX_W){1'b0}}, j_s2});

	always_comb begin
		for (int r = 0; r < GRID_D; r++) begin
			for (int c = 0; c < GRID_D; c++) begin
				pos_c[r][c] = base_s2[r] + POS_W'(c - GRID_R);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < GRID_D; r++) begin
				for (int c = 0; c < GRID_D; c++) begin
					pos_s3[r][c] <= pos_c[r][c][COL_W-1:0];
					lt_s3[r][c]  <= j_ext < pos_c[r][c];
					eq_s3[r][c]  <= j_ext == pos_c[r][c];
				end
			end
			flags_s3 <= flags_s2;
			fb_s3    <= fb_s2;
		end
	end

	// Stage 4: per stencil, the tap that matches the column and its candidate;
	// for the fallback list, the first neighbor beyond the column.
	logic signed [COEF_W-1:0] coef_c [NUM_ST];
	logic [COL_W-1:0]         cand_c [NUM_ST];
	logic [NUM_ST-1:0]        have_c;
	logic [COL_W-1:0]         fb_next_c;
	logic                     fb_have_c;

	always_comb begin
		for (int s = 0; s < NUM_ST; s++) begin
			logic found;
			found     = 1'b0;
			coef_c[s] = '0;
			cand_c[s] = '0;
			have_c[s] = 1'b0;
			for (int k = 0; k < MAX_TAP; k++) begin
				if (k < ST_CNT[s] && !found) begin
					if (lt_s3[ST_ROW[s][k]+GRID_R][ST_COL[s][k]+GRID_R]) begin
						found     = 1'b1;
						have_c[s] = 1'b1;
						cand_c[s] = pos_s3[ST_ROW[s][k]+GRID_R][ST_COL[s][k]+GRID_R];
					end else if (eq_s3[ST_ROW[s][k]+GRID_R][ST_COL[s][k]+GRID_R]) begin
						found     = 1'b1;
						coef_c[s] = COEF_W'(ST_COEF[s][k]);
						if (k + 1 < ST_CNT[s]) begin
							have_c[s] = 1'b1;
							cand_c[s] = pos_s3[ST_ROW[s][(k < MAX_TAP-1) ? k+1 : k] + GRID_R]
								[ST_COL[s][(k < MAX_TAP-1) ? k+1 : k] + GRID_R];
						end
					end
				end
			end
			// A disabled stencil adds nothing.
			if (!flags_s3[s]) begin
				coef_c[s] = '0;
				have_c[s] = 1'b0;
			end
		end

		fb_next_c = '0;
		fb_have_c = 1'b0;
		for (int k = 0; k < NUM_FB; k++) begin
			if (!fb_have_c && lt_s3[FB_ROW[k]+GRID_R][FB_COL[k]+GRID_R]) begin
				fb_have_c = 1'b1;
				fb_next_c = pos_s3[FB_ROW[k]+GRID_R][FB_COL[k]+GRID_R];
			end
		end
	end

	logic signed [COEF_W-1:0] coef_s4 [NUM_ST];
	logic [COL_W-1:0]         cand_s4 [NUM_ST];
	logic [NUM_ST-1:0]        have_s4;
	logic [COL_W-1:0]         fb_next_s4;
	logic                     fb_have_s4;
	logic                     fb_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			coef_s4    <= coef_c;
			cand_s4    <= cand_c;
			have_s4    <= have_c;
			fb_next_s4 <= fb_next_c;
			fb_have_s4 <= fb_have_c;
			fb_s4      <= fb_s3;
		end
	end

	// Coefficient times weight, as shifts and a negation.
	function automatic logic signed [SUM_W-1:0] coef_term(
		input logic signed [COEF_W-1:0] coef,
		input logic [WGT_W-1:0]         w
	);
		logic signed [SUM_W-1:0] we;
		logic signed [SUM_W-1:0] res;
		we = signed'({{(SUM_W-WGT_W){1'b0}}, w});
		case (coef)
			4'sd1:   res = we;
			-4'sd1:  res = -we;
			4'sd2:   res = we <<< 1;
			-4'sd2:  res = -(we <<< 1);
			4'sd4:   res = we <<< 2;
			-4'sd4:  res = -(we <<< 2);
			default: res = '0;
		endcase
		return res;
	endfunction

	// Stage 5: terms, then sum and minimum within each group of stencils.
	logic signed [SUM_W-1:0] gsum_c [NUM_GRP];
	logic [COL_W-1:0]        gmin_c [NUM_GRP];
	logic [NUM_GRP-1:0]      ghave_c;

	always_comb begin
		for (int g = 0; g < NUM_GRP; g++) begin
			gsum_c[g]  = '0;
			gmin_c[g]  = '0;
			ghave_c[g] = 1'b0;
			for (int m = 0; m < GRP_N; m++) begin
				gsum_c[g] = gsum_c[g] + coef_term(coef_s4[g*GRP_N+m],
					(ST_WSEL[g*GRP_N+m] == WSEL_X) ? weight_x_q :
					(ST_WSEL[g*GRP_N+m] == WSEL_Y) ? weight_y_q : weight_cross_q);
				if (have_s4[g*GRP_N+m] &&
						(!ghave_c[g] || cand_s4[g*GRP_N+m] < gmin_c[g])) begin
					ghave_c[g] = 1'b1;
					gmin_c[g]  = cand_s4[g*GRP_N+m];
				end
			end
		end
	end

	logic signed [SUM_W-1:0] gsum_s5 [NUM_GRP];
	logic [COL_W-1:0]        gmin_s5 [NUM_GRP];
	logic [NUM_GRP-1:0]      ghave_s5;
	logic [COL_W-1:0]        fb_next_s5;
	logic                    fb_have_s5;
	logic                    fb_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			gsum_s5    <= gsum_c;
			gmin_s5    <= gmin_c;
			ghave_s5   <= ghave_c;
			fb_next_s5 <= fb_next_s4;
			fb_have_s5 <= fb_have_s4;
			fb_s5      <= fb_s4;
		end
	end

	// Stage 6: combine the groups, pick the fallback result, and drive the output.
	logic signed [SUM_W-1:0] sum_c;
	logic [COL_W-1:0]        next_c;
	logic                    have_c6;
	logic [VAL_W-1:0]        val_s6;
	logic [COL_W-1:0]        next_s6;
	logic                    none_s6;

	always_comb begin
		sum_c   = '0;
		next_c  = '0;
		have_c6 = 1'b0;
		for (int g = 0; g < NUM_GRP; g++) begin
			sum_c = sum_c + gsum_s5[g];
			if (ghave_s5[g] && (!have_c6 || gmin_s5[g] < next_c)) begin
				have_c6 = 1'b1;
				next_c  = gmin_s5[g];
			end
		end
		if (fb_s5) begin
			sum_c   = '0;
			have_c6 = fb_have_s5;
			next_c  = fb_next_s5;
		end
		if (!have_c6) begin
			next_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_s6  <= sum_c[VAL_W-1:0];
			next_s6 <= next_c;
			none_s6 <= !have_c6;
		end
	end

	assign m_tdata = {{(OUT_DATA_W-VAL_W-COL_W-1){1'b0}}, none_s6, next_s6, val_s6};

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`default_nettype none

module testbench
	import mcse_pkg::*;
();

	localparam int  CLK_HALF      = 10;
	localparam int  RUN_LIMIT     = 400000 * 2 * CLK_HALF;
	localparam int  PHASES        = 9;
	localparam int  RANDOM_ITEMS  = 172;
	localparam int  WIDTH_CAP     = 4096;
	localparam int  STENCIL_COUNT = 10;
	localparam int  NEIGHBOR_COUNT = 13;
	localparam logic [19:0] IDX_TOP = 20'hFFFFF;

	// Which weight register a stencil scales.
	typedef enum int {
		SCALE_X,
		SCALE_Y,
		SCALE_CROSS
	} weight_kind_t;

	// Stencil taps: row offset in grid rows, column offset in cells, coefficient.
	localparam int TAP_COUNT [STENCIL_COUNT] = '{3, 3, 3, 4, 4, 4, 4, 3, 3, 3};
	localparam weight_kind_t TAP_SCALE [STENCIL_COUNT] = '{SCALE_X, SCALE_X, SCALE_X,
		SCALE_CROSS, SCALE_CROSS, SCALE_CROSS, SCALE_CROSS, SCALE_Y, SCALE_Y, SCALE_Y};
	localparam int TAP_ROW [STENCIL_COUNT][4] = '{
		'{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0},
		'{0, 0, 1, 1}, '{0, 0, 1, 1}, '{-1, -1, 0, 0}, '{-1, -1, 0, 0},
		'{0, 1, 2, 0}, '{-1, 0, 1, 0}, '{-2, -1, 0, 0}};
	localparam int TAP_COL [STENCIL_COUNT][4] = '{
		'{0, 1, 2, 0}, '{-1, 0, 1, 0}, '{-2, -1, 0, 0},
		'{0, 1, 0, 1}, '{-1, 0, -1, 0}, '{0, 1, 0, 1}, '{-1, 0, -1, 0},
		'{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}};
	localparam int TAP_COEF [STENCIL_COUNT][4] = '{
		'{1, -2, 1, 0}, '{-2, 4, -2, 0}, '{1, -2, 1, 0},
		'{1, -1, -1, 1}, '{-1, 1, 1, -1}, '{-1, 1, 1, -1}, '{1, -1, -1, 1},
		'{1, -2, 1, 0}, '{-2, 4, -2, 0}, '{1, -2, 1, 0}};

	// Neighbor offsets for the zero element, scanned in this order.
	localparam int NEIGH_ROW [NEIGHBOR_COUNT] = '{-2, -1, -1, -1, 0, 0, 0, 0, 0, 1, 1, 1, 2};
	localparam int NEIGH_COL [NEIGHBOR_COUNT] = '{0, -1, 0, 1, -2, -1, 0, 1, 2, -1, 0, 1, 0};

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic [COL_W-1:0]        next_col;
		logic                    next_none;
	} element_t;

	// Holds a copy of the registers and the elements still owed by the block.
	class element_tracker;
		logic [NN_W-1:0]  row_width;
		logic [WGT_W-1:0] weight_x;
		logic [WGT_W-1:0] weight_y;
		logic [WGT_W-1:0] weight_cross;
		element_t         owed_elements[$];
		int               errors;

		function new();
			row_width    = ROW_WIDTH_RST;
			weight_x     = WEIGHT_RST;
			weight_y     = WEIGHT_RST;
			weight_cross = WEIGHT_RST;
			errors       = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [WGT_W-1:0] val);
			case (idx)
				REG_ROW_WIDTH:    row_width    = val[NN_W-1:0];
				REG_WEIGHT_X:     weight_x     = val;
				REG_WEIGHT_Y:     weight_y     = val;
				REG_WEIGHT_CROSS: weight_cross = val;
				default: ;
			endcase
		endfunction

		// Zero width acts as one; widths above the cap act as the cap.
		function longint effective_width();
			longint w;
			w = longint'(row_width);
			if (w == 0)
				w = 1;
			if (w > WIDTH_CAP)
				w = WIDTH_CAP;
			return w;
		endfunction

		function element_t compute_element(logic [IDX_W-1:0] row_idx,
				logic [IDX_W-1:0] col_idx, logic fixed, logic [FLAGS_W-1:0] flags);
			element_t res;
			longint   i, j, nn, acc, best, pos, cand, w;
			bit       none, have;
			int       s, k;
			i    = longint'(row_idx);
			j    = longint'(col_idx);
			nn   = effective_width();
			acc  = 0;
			best = 0;
			cand = 0;
			none = 1'b1;
			if (fixed || flags == '0) begin
				// Zero element: first neighbor beyond the column.
				for (k = 0; k < NEIGHBOR_COUNT; k++) begin
					pos = i + NEIGH_ROW[k] * nn + NEIGH_COL[k];
					if (j < pos) begin
						best = pos;
						none = 1'b0;
						break;
					end
				end
			end else begin
				for (s = 0; s < STENCIL_COUNT; s++) begin
					if (!flags[s])
						continue;
					case (TAP_SCALE[s])
						SCALE_X: w = longint'(weight_x);
						SCALE_Y: w = longint'(weight_y);
						default: w = longint'(weight_cross);
					endcase
					// The first tap at or beyond the column decides for this stencil.
					for (k = 0; k < TAP_COUNT[s]; k++) begin
						pos  = i + TAP_ROW[s][k] * nn + TAP_COL[s][k];
						have = 1'b0;
						if (j < pos) begin
							cand = pos;
							have = 1'b1;
						end else if (j == pos) begin
							acc += TAP_COEF[s][k] * w;
							if (k + 1 < TAP_COUNT[s]) begin
								cand = i + TAP_ROW[s][k+1] * nn + TAP_COL[s][k+1];
								have = 1'b1;
							end
						end else begin
							continue;
						end
						if (have && (none || cand < best)) begin
							best = cand;
							none = 1'b0;
						end
						break;
					end
				end
			end
			res.value     = acc[VAL_W-1:0];
			res.next_col  = none ? '0 : best[COL_W-1:0];
			res.next_none = none;
			return res;
		endfunction

		function void note_request(logic [IN_DATA_W-1:0] data);
			owed_elements.push_back(compute_element(data[19:0], data[39:20],
				data[40] | data[41], data[51:42]));
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] data);
			element_t want;
			element_t got;
			got.value     = data[37:0];
			got.next_col  = data[58:38];
			got.next_none = data[59];
			if (owed_elements.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, data);
				errors++;
				return;
			end
			want = owed_elements.pop_front();
			if (got.value !== want.value) begin
				$display("%0t: element_value expected %h actual %h", $time,
					want.value, got.value);
				errors++;
			end
			if (got.next_col !== want.next_col) begin
				$display("%0t: next_column expected %h actual %h", $time,
					want.next_col, got.next_col);
				errors++;
			end
			if (got.next_none !== want.next_none) begin
				$display("%0t: next_none expected %b actual %b", $time,
					want.next_none, got.next_none);
				errors++;
			end
		endfunction

		function bit pending();
			return owed_elements.size() != 0;
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	wire                    s_tready;
	logic [IN_DATA_W-1:0]   s_tdata = '0;
	wire                    m_tvalid;
	logic                   m_tready = 1'b0;
	wire  [OUT_DATA_W-1:0]  m_tdata;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = REG_ROW_WIDTH;
	logic [WGT_W-1:0]       cfg_data = '0;

	element_tracker tracker = new();
	bit             send_steady = 1'b0;

	masked_curvature_stencil_element i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock generation.
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic logic [IN_DATA_W-1:0] pack_request(logic [19:0] row_idx,
			logic [19:0] col_idx, logic rf, logic cf, logic [9:0] flags);
		return {4'b0, flags, cf, rf, col_idx, row_idx};
	endfunction

	// Mostly requests whose column lies on or next to a stencil tap.
	function automatic logic [IN_DATA_W-1:0] random_request(longint nn);
		logic [19:0] row_idx, col_idx;
		logic [9:0]  flags;
		longint      j;
		int          span;
		span = int'(3 * nn + 4);
		case ($urandom_range(0, 5))
			0:       row_idx = 20'($urandom_range(0, span));
			1:       row_idx = IDX_TOP - 20'($urandom_range(0, span));
			default: row_idx = 20'($urandom);
		endcase
		if ($urandom_range(0, 3) != 0) begin
			j = longint'(row_idx) + (int'($urandom_range(0, 4)) - 2) * nn
				+ (int'($urandom_range(0, 6)) - 3);
			if ($urandom_range(0, 7) == 0)
				j += int'($urandom_range(0, 6)) - 3;
			if (j < 0 || j > longint'(IDX_TOP))
				col_idx = 20'($urandom);
			else
				col_idx = j[19:0];
		end else begin
			col_idx = 20'($urandom);
		end
		case ($urandom_range(0, 7))
			0:       flags = 10'h1 << $urandom_range(0, 9);
			1:       flags = '1;
			2:       flags = ($urandom_range(0, 3) == 0) ? 10'h0 : 10'($urandom);
			default: flags = 10'($urandom);
		endcase
		return pack_request(row_idx, col_idx, $urandom_range(0, 9) == 0,
			$urandom_range(0, 9) == 0, flags);
	endfunction

	// Offer one request after a random gap and hold it until the transfer.
	task automatic send_request(logic [IN_DATA_W-1:0] data);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_steady = !send_steady;
		gap = send_steady ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		do @(posedge clk); while (s_tready !== 1'b1);
		tracker.note_request(data);
	endtask

	// Write one register; the caller lowers the write enable after a batch.
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [WGT_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		tracker.set_register(idx, val);
	endtask

	task automatic apply_setting(int phase);
		logic [12:0] rw;
		logic [31:0] wx, wy, wc;
		wx = $urandom;
		wy = $urandom;
		wc = $urandom;
		case (phase)
			1: begin
				rw = 13'd1;
				wx = '1;
				wy = '1;
				wc = '1;
			end
			2: begin
				rw = 13'd0;
				wx = '0;
				wy = '0;
				wc = '0;
			end
			3: rw = 13'd2;
			4: rw = 13'd3;
			5: begin
				rw = 13'd4096;
				wy = '1;
				wc = '0;
			end
			6: rw = 13'h1FFF;
			7: rw = 13'($urandom_range(4, 4096));
			default: rw = 13'($urandom_range(4097, 8191));
		endcase
		// Upper data bits are don't-care for the row width.
		write_register(REG_ROW_WIDTH, ($urandom & 32'hFFFFE000) | 32'(rw));
		write_register(REG_WEIGHT_X, wx);
		write_register(REG_WEIGHT_Y, wy);
		write_register(REG_WEIGHT_CROSS, wc);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (tracker.pending())
			@(posedge clk);
	endtask

	// Edge and corner requests at the default width of 64.
	task automatic send_directed_defaults();
		int s;
		send_request(pack_request(20'd0, 20'd0, 1'b0, 1'b0, 10'h3FF));
		send_request(pack_request(IDX_TOP, IDX_TOP, 1'b0, 1'b0, 10'h3FF));
		send_request(pack_request(IDX_TOP, 20'd0, 1'b1, 1'b0, 10'h3FF));
		send_request(pack_request(20'd0, IDX_TOP, 1'b0, 1'b1, 10'h3FF));
		send_request(pack_request(20'd500, 20'd436, 1'b1, 1'b1, 10'h155));
		send_request(pack_request(20'd100, 20'd100, 1'b0, 1'b0, 10'h000));
		send_request(pack_request(20'd0, IDX_TOP, 1'b0, 1'b0, 10'h000));
		send_request(pack_request(20'd5, IDX_TOP, 1'b0, 1'b0, 10'h3FF));
		// Taps that fall below zero never match.
		send_request(pack_request(20'd1, 20'd0, 1'b0, 1'b0, 10'h004));
		send_request(pack_request(20'd64, 20'd0, 1'b0, 1'b0, 10'h240));
		for (s = 0; s < STENCIL_COUNT; s++)
			send_request(pack_request(20'd1000, 20'd1000, 1'b0, 1'b0, 10'h1 << s));
	endtask

	// Coinciding taps at width one.
	task automatic send_directed_narrow();
		send_request(pack_request(20'd10, 20'd10, 1'b0, 1'b0, 10'h030));
		send_request(pack_request(20'd10, 20'd9, 1'b0, 1'b0, 10'h3FF));
		send_request(pack_request(20'd10, 20'd11, 1'b0, 1'b0, 10'h3FF));
		send_request(pack_request(20'd0, 20'd0, 1'b0, 1'b0, 10'h058));
	endtask

	// Result side: random stalls before each transfer, with steady stretches.
	initial begin
		int gap;
		bit steady;
		steady = 1'b0;
		forever begin
			if ($urandom_range(0, 39) == 0)
				steady = !steady;
			gap = steady ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			tracker.check_result(m_tdata);
		end
	end

	// Main sequence: reset, then phases of register settings and requests.
	initial begin
		int phase, n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				wait_drained();
				apply_setting(phase);
			end
			if (phase == 0)
				send_directed_defaults();
			if (phase == 1)
				send_directed_narrow();
			for (n = 0; n < RANDOM_ITEMS; n++)
				send_request(random_request(tracker.effective_width()));
			s_tvalid <= 1'b0;
		end
		wait_drained();
		repeat (12) @(posedge clk);
		if (tracker.errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	// Watchdog.
	initial begin
		#RUN_LIMIT;
		$display("testbench: errors");
		$finish;
	end

endmodule

`default_nettype wire

// ----- masked_curvature_stencil_element.f -----
rtl/mcse_pkg.sv
rtl/masked_curvature_stencil_element.sv
bench/testbench.sv
